>>> design/fqs_pkg.sv
package fqs_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = $clog2(DEPTH);
    localparam int IN_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_BITS   = DATA_WIDTH + POS_W + 3;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_PEEK   = 2'd2,
        REQ_SEARCH = 2'd3
    } t_req;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

    typedef struct packed {
        logic                  overflow;
        logic                  now_empty;
        logic [POS_W-1:0]      position;
        logic                  found;
        logic [DATA_WIDTH-1:0] result_value;
    } t_result;

endpackage

>>> design/fqs_cell.sv
module fqs_cell
    import fqs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic                  i_prev_valid,
    input  logic                  i_next_valid,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match
);

    logic                  r_valid;
    logic                  n_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctrl.pop) begin
            n_valid = i_next_valid;
            n_data  = i_next_data;
        end else if (i_ctrl.push && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_data  = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_match = r_valid && (r_data == i_key);

endmodule

>>> design/fifo_queue_with_search.sv
// fifo queue with content search, built as a row of storage cells with the
// head in cell 0
// slave stream: s_axis_tuser carries the request kind (push, pop, peek,
// search), s_axis_tdata the word to push or to look for
// master stream: one result transaction per request with the head word for
// pop and peek, found flag and position for search, empty and overflow flags
// result: it is registered and shows in the cycle after the request is taken
// throughput: one request per cycle while ready; a pop shifts every cell one
// place toward the head, a push fills the first empty cell, a search compares
// all cells at once and a priority encoder picks the match nearest the head
// stall: while the output register holds an untaken result and m_axis_tready
// is low, s_axis_tready drops and the queue state holds
// reset: all cells read empty, the output register is emptied
module fifo_queue_with_search
    import fqs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // value
    input  logic [1:0]             s_axis_tuser,  // req_type
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // result_value, found, position, now_empty, overflow, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic                  w_accept;
    t_req                  w_req;
    logic [DATA_WIDTH-1:0] w_key;
    t_cell_ctrl            w_ctrl;
    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_match;
    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic                  w_full;
    logic                  w_empty;
    t_result               w_res;
    logic                  w_found;
    logic [POS_W-1:0]      w_pos;

    logic                  r_out_valid;
    t_result               r_out;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_req         = t_req'(s_axis_tuser);
    assign w_key         = s_axis_tdata[DATA_WIDTH-1:0];
    assign w_full        = w_valid[DEPTH-1];
    assign w_empty       = !w_valid[0];

    assign w_ctrl.push = w_accept && (w_req == REQ_PUSH) && !w_full;
    assign w_ctrl.pop  = w_accept && (w_req == REQ_POP) && !w_empty;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                  w_prev_valid;
            logic                  w_next_valid;
            logic [DATA_WIDTH-1:0] w_next_data;
            if (g == 0) begin : g_first
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_valid = w_valid[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_next_valid = 1'b0;
                assign w_next_data  = w_data[g];
            end else begin : g_inner
                assign w_next_valid = w_valid[g+1];
                assign w_next_data  = w_data[g+1];
            end
            fqs_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_key        (w_key),
                .i_prev_valid (w_prev_valid),
                .i_next_valid (w_next_valid),
                .i_next_data  (w_next_data),
                .o_valid      (w_valid[g]),
                .o_data       (w_data[g]),
                .o_match      (w_match[g])
            );
        end
    endgenerate

    // first match from the head
    always_comb begin
        w_pos = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_match[i]) begin
                w_pos = POS_W'(i);
            end
        end
    end

    assign w_found = |w_match;

    always_comb begin
        w_res = '0;
        case (w_req)
            REQ_PUSH: begin
                w_res.overflow = w_full;
            end
            REQ_POP: begin
                w_res.result_value = w_empty ? '0 : w_data[0];
                w_res.now_empty    = !w_valid[1];
            end
            REQ_PEEK: begin
                w_res.result_value = w_empty ? '0 : w_data[0];
                w_res.now_empty    = w_empty;
            end
            REQ_SEARCH: begin
                w_res.found     = w_found;
                w_res.position  = w_found ? w_pos : '0;
                w_res.now_empty = w_empty;
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, r_out};

    a_cells_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[DEPTH-1:1] & ~w_valid[DEPTH-2:0]) == '0)
        else $error("occupied cell after an empty one");

    a_push_fills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.push |=> w_valid[0])
        else $error("push left the head cell empty");

    a_overflow_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && r_out.overflow |-> !r_out.now_empty && r_out.result_value == '0)
        else $error("overflow result with empty queue or data");

    a_pos_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !r_out.found |-> r_out.position == '0)
        else $error("position set without a match");

    a_pop_shifts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.pop && !w_valid[1] |=> !w_valid[0])
        else $error("pop of last word left the queue occupied");

endmodule
